FILE: rtl/gtg_pkg.sv
// Package for the go-to-goal controller: constants, register indexes and the atan table.
package gtg_pkg;
  localparam int PosW  = 27;
  localparam int QuatW = 16;
  localparam int GainW = 16;
  localparam int LinW  = 19;
  localparam int AngW  = 17;
  localparam int CfgW  = 27;

  localparam logic [2:0] REG_GOAL_X       = 3'd0;
  localparam logic [2:0] REG_GOAL_Y       = 3'd1;
  localparam logic [2:0] REG_LINEAR_GAIN  = 3'd2;
  localparam logic [2:0] REG_HEADING_GAIN = 3'd3;
  localparam logic [2:0] REG_MAX_LINEAR   = 3'd4;
  localparam logic [2:0] REG_MAX_ANGULAR  = 3'd5;
  localparam logic [2:0] REG_REACH_RADIUS = 3'd6;

  // angles in Q3.13 (final) and 2^-16 rad (cordic accumulator)
  localparam logic signed [17:0] PI_Q13     = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
  localparam logic signed [19:0] PI_HALF_Q16 = 20'sd102944;

  // atan(2^-i) in 2^-16 rad; entry 0 is the model's own value
  function automatic logic [16:0] atan_lut(input logic [4:0] i);
    unique case (i)
      5'd0: atan_lut = 17'd51472;
      5'd1: atan_lut = 17'd30386;
      5'd2: atan_lut = 17'd16055;
      5'd3: atan_lut = 17'd8150;
      5'd4: atan_lut = 17'd4091;
      5'd5: atan_lut = 17'd2047;
      5'd6: atan_lut = 17'd1024;
      5'd7: atan_lut = 17'd512;
      5'd8: atan_lut = 17'd256;
      5'd9: atan_lut = 17'd128;
      5'd10: atan_lut = 17'd64;
      5'd11: atan_lut = 17'd32;
      5'd12: atan_lut = 17'd16;
      5'd13: atan_lut = 17'd8;
      5'd14: atan_lut = 17'd4;
      5'd15: atan_lut = 17'd2;
      5'd16: atan_lut = 17'd1;
      default: atan_lut = 17'd0;
    endcase
  endfunction
endpackage

FILE: rtl/gtg_mul.sv
// Shift-add serial multiplier: one multiplier bit per cycle, unsigned operands.
module gtg_mul import gtg_pkg::*; #(
  parameter int AW = 56,
  parameter int BW = 56
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output logic               done,
  output logic [AW+BW-1:0]   prod
);
  localparam int CW = $clog2(BW + 1);
  logic [AW+BW-1:0] acc;
  logic [AW+BW-1:0] mcand;
  logic [BW-1:0]    mplier;
  logic [CW-1:0]    cnt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(BW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= {{BW{1'b0}}, a};
      mplier <= b;
    end else if (busy) begin
      if (mplier[0]) acc <= acc + mcand;
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign prod = acc;
endmodule

FILE: rtl/gtg_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
module gtg_sqrt import gtg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [55:0] val,
  output logic        done,
  output logic [27:0] root
);
  logic [55:0] rem;
  logic [55:0] r;
  logic [57:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [57:0] trial;

  assign trial = {2'b00, r} + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd28;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // r holds root shifted: classic digit-by-digit method over a 56-bit radicand
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= val;
      r    <= '0;
      bitv <= 58'd1 << 54;
    end else if (busy) begin
      if ({2'b00, rem} >= trial) begin
        rem <= 56'({2'b00, rem} - trial);
        r   <= 56'(({2'b00, r} >> 1) + bitv);
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign root = r[27:0];
endmodule

FILE: rtl/gtg_cordic.sv
// CORDIC vectoring atan2, one micro-rotation per cycle, result Q3.13 clamped to +-pi.
module gtg_cordic import gtg_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [35:0] yin,
  input  logic signed [35:0] xin,
  output logic               done,
  output logic signed [17:0] angle
);
  localparam int SW = $clog2(STEPS + 1);
  logic signed [57:0] x, y;
  logic signed [24:0] z;
  logic [SW-1:0]      cnt;
  logic [4:0]         sh;
  logic               busy;
  logic signed [57:0] xs, ys, x0, y0;
  logic signed [24:0] z0, zr;
  logic signed [16:0] zq;

  assign sh = 5'(cnt);
  assign xs = x >>> sh;
  assign ys = y >>> sh;

  always_comb begin
    x0 = 58'(xin) <<< 20;
    y0 = 58'(yin) <<< 20;
    z0 = '0;
    if (xin < 0) begin
      if (yin >= 0) begin
        x0 = 58'(yin) <<< 20;
        y0 = -(58'(xin) <<< 20);
        z0 = 25'(PI_HALF_Q16);
      end else begin
        x0 = -(58'(yin) <<< 20);
        y0 = 58'(xin) <<< 20;
        z0 = -25'(PI_HALF_Q16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == SW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= x0;
      y <= y0;
      z <= z0;
    end else if (busy) begin
      if (y >= 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + 25'(atan_lut(sh));
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - 25'(atan_lut(sh));
      end
    end
  end

  assign zr = (z + 25'sd4) >>> 3;
  assign zq = 17'(zr);
  always_comb begin
    if (zr > 25'(PI_Q13)) angle = PI_Q13;
    else if (zr < -25'(PI_Q13)) angle = -PI_Q13;
    else angle = 18'(zq);
  end
endmodule

FILE: rtl/go_to_goal_pose_controller.sv
// Top level of the go-to-goal pose controller: sequencer, config registers and output register.
//
//  channel | direction | handshake        | payload
//  pose    | in        | pose_valid/stall | pose_x pose_y quat_x..quat_w arm
//  cmd     | out       | cmd_valid/stall  | linear_cmd angular_cmd goal_reached
//  cfg     | in        | cfg_we           | cfg_index cfg_data
//
// A disarmed sample is taken and the next may follow at once. A reached sample gives its
// result after three serial products: dx squared, dy squared and reach radius squared. A
// command sample runs thirteen products, a square root and two CORDIC passes; under
// gimbal lock the yaw CORDIC pass is skipped. Reset is synchronous and disarms. Pose stall
// is high while a sample is in work or a result waits; a stalled result holds until taken.
module go_to_goal_pose_controller import gtg_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pose_valid,
  output logic                     pose_stall,
  input  logic signed [PosW-1:0]   pose_x,
  input  logic signed [PosW-1:0]   pose_y,
  input  logic signed [QuatW-1:0]  quat_x,
  input  logic signed [QuatW-1:0]  quat_y,
  input  logic signed [QuatW-1:0]  quat_z,
  input  logic signed [QuatW-1:0]  quat_w,
  input  logic                     arm,
  output logic                     cmd_valid,
  input  logic                     cmd_stall,
  output logic [LinW-1:0]          linear_cmd,
  output logic signed [AngW-1:0]   angular_cmd,
  output logic                     goal_reached,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [CfgW-1:0]          cfg_data
);
  localparam logic [4:0] S_IDLE = 5'd0,  S_DX2 = 5'd1,  S_DY2 = 5'd2,  S_RR = 5'd3,
                         S_CMP = 5'd4,  S_SQRT = 5'd5, S_LIN = 5'd6,  S_BEAR = 5'd7,
                         S_QXX = 5'd8,  S_QYY = 5'd9,  S_QZZ = 5'd10, S_QWW = 5'd11,
                         S_QXZ = 5'd12, S_QWY = 5'd13, S_QXY = 5'd14, S_QWZ = 5'd15,
                         S_YAWC = 5'd16, S_YAW = 5'd17, S_ANG = 5'd18, S_OUT = 5'd19;

  logic signed [PosW-1:0] goal_x, goal_y;
  logic [GainW-1:0] linear_gain, heading_gain, max_angular;
  logic [LinW-1:0]  max_linear, reach_radius;
  logic armed;
  logic [4:0] state;

  logic signed [PosW:0] dx, dy;
  logic signed [QuatW-1:0] qx, qy, qz, qw;
  logic [55:0] d2;
  logic [35:0] n, sxz, swy, sxy, swz, syz2;
  logic [27:0] distance;
  logic [LinW-1:0] lin;
  logic signed [17:0] bearing, yaw;

  // shared serial multiplier, magnitudes in, sign fixed afterwards
  logic        m_start, m_done, m_neg, m_neg_q;
  logic [55:0] m_a, m_b;
  logic [111:0] m_p;
  logic signed [56:0] m_sp;
  gtg_mul #(.AW(56), .BW(56)) u_mul (
    .clk(clk), .rst(rst), .start(m_start), .a(m_a), .b(m_b), .done(m_done), .prod(m_p)
  );
  assign m_sp = m_neg_q ? -57'(m_p[55:0]) : 57'(m_p[55:0]);

  logic s_start, s_done;
  logic [27:0] s_root;
  gtg_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(s_start), .val(d2), .done(s_done), .root(s_root)
  );

  logic c_start, c_done;
  logic signed [35:0] c_y, c_x;
  logic signed [17:0] c_ang;
  gtg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(c_start), .yin(c_y), .xin(c_x), .done(c_done), .angle(c_ang)
  );

  logic pend;   // operation launched, waiting for its unit
  logic signed [35:0] g_abs_s, n_s, yv, xv;
  logic signed [18:0] err;
  logic signed [18:0] err_w;
  logic signed [35:0] ang_full;
  logic signed [35:0] amax;

  // operand selection for each multiply state
  function automatic logic [55:0] mag(input logic signed [27:0] v);
    mag = 56'(v < 0 ? -v : v);
  endfunction

  always_comb begin
    m_a = '0;
    m_b = '0;
    m_neg = 1'b0;
    unique case (state)
      S_DX2: begin m_a = mag(dx); m_b = mag(dx); end
      S_DY2: begin m_a = mag(dy); m_b = mag(dy); end
      S_RR:  begin m_a = 56'(reach_radius); m_b = 56'(reach_radius); end
      S_LIN: begin m_a = 56'(linear_gain); m_b = 56'(distance); end
      S_QXX: begin m_a = mag(28'(qx)); m_b = mag(28'(qx)); end
      S_QYY: begin m_a = mag(28'(qy)); m_b = mag(28'(qy)); end
      S_QZZ: begin m_a = mag(28'(qz)); m_b = mag(28'(qz)); end
      S_QWW: begin m_a = mag(28'(qw)); m_b = mag(28'(qw)); end
      S_QXZ: begin m_a = mag(28'(qx)); m_b = mag(28'(qz)); m_neg = qx[15] ^ qz[15]; end
      S_QWY: begin m_a = mag(28'(qw)); m_b = mag(28'(qy)); m_neg = qw[15] ^ qy[15]; end
      S_QXY: begin m_a = mag(28'(qx)); m_b = mag(28'(qy)); m_neg = qx[15] ^ qy[15]; end
      S_QWZ: begin m_a = mag(28'(qw)); m_b = mag(28'(qz)); m_neg = qw[15] ^ qz[15]; end
      S_ANG: begin
        m_a = 56'(heading_gain);
        m_b = mag(28'(err_w));
        m_neg = err_w < 0;
      end
      default: ;
    endcase
  end

  always_comb begin
    m_start = 1'b0;
    s_start = 1'b0;
    c_start = 1'b0;
    unique case (state)
      S_DX2, S_DY2, S_RR, S_LIN, S_QXX, S_QYY, S_QZZ, S_QWW,
      S_QXZ, S_QWY, S_QXY, S_QWZ, S_ANG: m_start = !pend;
      S_SQRT: s_start = !pend;
      S_BEAR, S_YAW: c_start = !pend;
      default: ;
    endcase
  end

  assign g_abs_s = $signed(sxz) < 0 ? 36'(-$signed(sxz)) : 36'(sxz);
  assign n_s = $signed(n);
  assign yv = state == S_BEAR ? 36'(dy) : 36'($signed(sxy) + $signed(swz)) <<< 1;
  assign xv = state == S_BEAR ? 36'(dx) : n_s - ($signed(syz2) <<< 1);
  assign c_y = yv;
  assign c_x = xv;

  assign err_w = (err > 19'(PI_Q13)) ? err - 19'(TWO_PI_Q13) : err;
  assign ang_full = $signed(m_sp[35:0]) + 36'sd128 >>> 8;
  assign amax = 36'(max_angular);

  assign pose_stall = state != S_IDLE || cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x <= '0;
      goal_y <= '0;
      linear_gain <= GainW'(256);
      heading_gain <= GainW'(256);
      max_linear <= '0;
      max_angular <= '0;
      reach_radius <= LinW'(6554);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GOAL_X:       goal_x <= cfg_data;
        REG_GOAL_Y:       goal_y <= cfg_data;
        REG_LINEAR_GAIN:  linear_gain <= cfg_data[GainW-1:0];
        REG_HEADING_GAIN: heading_gain <= cfg_data[GainW-1:0];
        REG_MAX_LINEAR:   max_linear <= cfg_data[LinW-1:0];
        REG_MAX_ANGULAR:  max_angular <= cfg_data[GainW-1:0];
        REG_REACH_RADIUS: reach_radius <= cfg_data[LinW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      armed <= 1'b0;
      cmd_valid <= 1'b0;
      pend <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) cmd_valid <= 1'b0;
      if (m_start || s_start || c_start) begin
        pend <= 1'b1;
        m_neg_q <= m_neg;
      end
      if (m_done || s_done || c_done) pend <= 1'b0;
      unique case (state)
        S_IDLE: if (pose_valid && !pose_stall) begin
          dx <= 28'(goal_x) - 28'(pose_x);
          dy <= 28'(goal_y) - 28'(pose_y);
          qx <= quat_x; qy <= quat_y; qz <= quat_z; qw <= quat_w;
          if (arm || armed) begin
            armed <= 1'b1;
            state <= S_DX2;
          end
        end
        S_DX2: if (m_done) begin d2 <= m_p[55:0]; state <= S_DY2; end
        S_DY2: if (m_done) begin d2 <= d2 + m_p[55:0]; state <= S_RR; end
        S_RR: if (m_done) begin
          if (d2 <= m_p[55:0]) begin
            armed <= 1'b0;
            linear_cmd <= '0;
            angular_cmd <= '0;
            goal_reached <= 1'b1;
            cmd_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_SQRT;
          end
        end
        S_SQRT: if (s_done) begin distance <= s_root; state <= S_LIN; end
        S_LIN: if (m_done) begin
          lin <= (m_p[55:8] > 48'(max_linear)) ? max_linear : LinW'(m_p[55:8]);
          state <= S_BEAR;
        end
        S_BEAR: if (c_done) begin
          bearing <= c_ang < 0 ? c_ang + TWO_PI_Q13 : c_ang;
          state <= S_QXX;
        end
        S_QXX: if (m_done) begin n <= 36'(m_p[35:0]); state <= S_QYY; end
        S_QYY: if (m_done) begin
          n <= n + 36'(m_p[35:0]); syz2 <= 36'(m_p[35:0]); state <= S_QZZ;
        end
        S_QZZ: if (m_done) begin
          n <= n + 36'(m_p[35:0]); syz2 <= syz2 + 36'(m_p[35:0]); state <= S_QWW;
        end
        S_QWW: if (m_done) begin n <= n + 36'(m_p[35:0]); state <= S_QXZ; end
        S_QXZ: if (m_done) begin sxz <= 36'(m_sp); state <= S_QWY; end
        S_QWY: if (m_done) begin sxz <= 36'($signed(sxz) - m_sp); state <= S_QXY; end
        S_QXY: if (m_done) begin sxy <= 36'(m_sp); state <= S_QWZ; end
        S_QWZ: if (m_done) begin swz <= 36'(m_sp); state <= S_YAWC; end
        S_YAWC: begin
          if ((g_abs_s <<< 1) >= n_s) begin
            yaw <= '0;
            state <= S_OUT;
          end else begin
            state <= S_YAW;
          end
        end
        S_YAW: if (c_done) begin yaw <= c_ang; state <= S_OUT; end
        S_OUT: begin
          err <= 19'(bearing) - 19'(yaw);
          state <= S_ANG;
        end
        S_ANG: if (m_done) begin
          linear_cmd <= lin;
          if (ang_full > 0) angular_cmd <= ang_full > amax ? 17'(amax) : 17'(ang_full);
          else angular_cmd <= ang_full < -amax ? 17'(-amax) : 17'(ang_full);
          goal_reached <= 1'b0;
          cmd_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the go-to-goal pose controller with its own fixed-point predictor.
module testbench;
  import gtg_pkg::*;

  localparam int LIMIT = 6000;
  localparam int STEPS = 16;

  typedef struct {
    logic signed [PosW-1:0] px, py;
    logic signed [QuatW-1:0] qx, qy, qz, qw;
    logic arm;
  } pose_t;

  typedef struct {
    logic [LinW-1:0] lin;
    logic signed [AngW-1:0] ang;
    logic reached;
  } cmd_t;

  logic clk, rst;
  logic pose_valid, pose_stall, arm;
  logic signed [PosW-1:0] pose_x, pose_y;
  logic signed [QuatW-1:0] quat_x, quat_y, quat_z, quat_w;
  logic cmd_valid, cmd_stall, goal_reached;
  logic [LinW-1:0] linear_cmd;
  logic signed [AngW-1:0] angular_cmd;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [CfgW-1:0] cfg_data;

  // predictor's copy of registers and state
  longint gx, gy;
  longint unsigned kv, kh, lin_cap, ang_cap, radius;
  bit is_armed;

  pose_t pending[$];
  cmd_t expected_cmds[$];
  int n_queued, n_taken, errors, idle_cycles, in_gap, out_hold;
  bit quiet;

  go_to_goal_pose_controller dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  const longint atan_q16[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                 256, 128, 64, 32, 16, 8, 4, 2};

  function automatic longint cordic_angle(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    x = x * 64'sd1048576;
    y = y * 64'sd1048576;
    if (x < 0) begin
      if (y >= 0) begin t = x; x = y; y = -t; z = 102944; end
      else begin t = x; x = -y; y = t; z = -102944; end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin x += ys; y -= xs; z += atan_q16[i]; end
      else begin x -= ys; y += xs; z -= atan_q16[i]; end
    end
    z = (z + 4) >>> 3;
    if (z > 25736) z = 25736;
    if (z < -25736) z = -25736;
    return z;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin v -= r + b; r = (r >> 1) + b; end
      else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint heading_of(longint qx, longint qy, longint qz, longint qw);
    longint n, g;
    n = qx*qx + qy*qy + qz*qz + qw*qw;
    g = 2 * (qx*qz - qw*qy);
    if (g < 0) g = -g;
    if (g >= n) return 0;  // gimbal lock
    return cordic_angle(2 * (qx*qy + qw*qz), n - 2 * (qy*qy + qz*qz));
  endfunction

  function automatic void predict_command(pose_t p);
    longint dx, dy, brg, err, a;
    longint unsigned d2, distance, lin;
    cmd_t c;
    if (p.arm) is_armed = 1;
    if (!is_armed) return;
    dx = gx - longint'(p.px);
    dy = gy - longint'(p.py);
    d2 = longint'(dx*dx) + longint'(dy*dy);
    if (d2 <= radius * radius) begin
      is_armed = 0;
      c.lin = '0; c.ang = '0; c.reached = 1;
      expected_cmds.push_back(c);
      return;
    end
    distance = root_floor(d2);
    lin = (kv * distance) >> 8;
    if (lin > lin_cap) lin = lin_cap;
    brg = cordic_angle(dy, dx);
    if (brg < 0) brg += 51472;
    if (brg >= 51472) brg -= 51472;
    err = brg - heading_of(p.qx, p.qy, p.qz, p.qw);
    if (err > 25736) err -= 51472;
    a = (longint'(kh) * err + 128) >>> 8;
    if (a > 0) begin if (a > longint'(ang_cap)) a = ang_cap; end
    else if (a < -longint'(ang_cap)) a = -longint'(ang_cap);
    c.lin = lin[LinW-1:0];
    c.ang = a[AngW-1:0];
    c.reached = 0;
    expected_cmds.push_back(c);
  endfunction

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // pose driver
  always @(posedge clk) begin
    if (rst) begin
      pose_valid <= 0;
      in_gap <= 0;
    end else if (!pose_valid || !pose_stall) begin
      if (pose_valid) begin
        predict_command('{pose_x, pose_y, quat_x, quat_y, quat_z, quat_w, arm});
        n_taken++;
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        pose_valid <= 0;
      end else if (pending.size() > 0) begin
        pose_t p;
        p = pending.pop_front();
        pose_x <= p.px; pose_y <= p.py;
        quat_x <= p.qx; quat_y <= p.qy; quat_z <= p.qz; quat_w <= p.qw;
        arm <= p.arm;
        pose_valid <= 1;
        in_gap <= pick_gap();
      end else pose_valid <= 0;
    end
  end

  // command monitor
  always @(posedge clk) begin
    if (rst) begin
      cmd_stall <= 0;
      out_hold <= 0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected command lin=%0d ang=%0d reached=%0b",
                   $time, linear_cmd, angular_cmd, goal_reached);
          errors++;
        end else begin
          cmd_t e;
          e = expected_cmds.pop_front();
          if (linear_cmd !== e.lin) begin
            $display("%0t: linear_cmd expected %0d got %0d", $time, e.lin, linear_cmd);
            errors++;
          end
          if (angular_cmd !== e.ang) begin
            $display("%0t: angular_cmd expected %0d got %0d", $time, e.ang, angular_cmd);
            errors++;
          end
          if (goal_reached !== e.reached) begin
            $display("%0t: goal_reached expected %0b got %0b", $time, e.reached,
                     goal_reached);
            errors++;
          end
        end
      end
      if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        cmd_stall <= 1;
      end else begin
        out_hold <= pick_gap();
        cmd_stall <= 0;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((pose_valid && !pose_stall) || (cmd_valid && !cmd_stall) || rst) idle_cycles <= 0;
    else if (idle_cycles >= LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  task automatic write_reg(logic [2:0] idx, longint unsigned v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v[CfgW-1:0];
    case (idx)
      REG_GOAL_X: gx = longint'(signed'(v[PosW-1:0]));
      REG_GOAL_Y: gy = longint'(signed'(v[PosW-1:0]));
      REG_LINEAR_GAIN: kv = v[15:0];
      REG_HEADING_GAIN: kh = v[15:0];
      REG_MAX_LINEAR: lin_cap = v[18:0];
      REG_MAX_ANGULAR: ang_cap = v[15:0];
      REG_REACH_RADIUS: radius = v[18:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic setup(longint unsigned x, y, g1, g2, l, a, r);
    write_reg(REG_GOAL_X, x);
    write_reg(REG_GOAL_Y, y);
    write_reg(REG_LINEAR_GAIN, g1);
    write_reg(REG_HEADING_GAIN, g2);
    write_reg(REG_MAX_LINEAR, l);
    write_reg(REG_MAX_ANGULAR, a);
    write_reg(REG_REACH_RADIUS, r);
  endtask

  task automatic drain();
    while (pending.size() > 0 || n_taken != n_queued || expected_cmds.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);  // margin before the registers are rewritten
  endtask

  task automatic add(longint px, py, logic [15:0] qx, qy, qz, qw, logic a);
    pose_t p;
    p.px = px[PosW-1:0]; p.py = py[PosW-1:0];
    p.qx = qx; p.qy = qy; p.qz = qz; p.qw = qw; p.arm = a;
    pending.push_back(p);
    n_queued++;
  endtask

  function automatic logic [15:0] rand_quat();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return 16'($urandom_range(0, 32768)) - 16'd16384;
  endfunction

  task automatic random_poses(int count);
    longint px, py, span;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        // land near the goal so reached results show up
        span = longint'(radius) * 2 + 4;
        px = gx + longint'($urandom_range(0, 2 * span)) - span;
        py = gy + longint'($urandom_range(0, 2 * span)) - span;
      end else if ($urandom_range(0, 2) == 0) begin
        px = gx + longint'($urandom_range(0, 2_000_000)) - 1_000_000;
        py = gy + longint'($urandom_range(0, 2_000_000)) - 1_000_000;
      end else begin
        px = longint'(signed'(27'($urandom())));
        py = longint'(signed'(27'($urandom())));
      end
      add(px, py, rand_quat(), rand_quat(), rand_quat(), rand_quat(),
          $urandom_range(0, 2) != 0);
    end
  endtask

  initial begin
    rst = 1;
    pose_valid = 0; pose_x = 0; pose_y = 0;
    quat_x = 0; quat_y = 0; quat_z = 0; quat_w = 0; arm = 0;
    cmd_stall = 0; cfg_we = 0; cfg_index = REG_GOAL_X; cfg_data = 0;
    gx = 0; gy = 0; kv = 256; kh = 256; lin_cap = 0; ang_cap = 0; radius = 6554;
    is_armed = 0; n_queued = 0; n_taken = 0; errors = 0; idle_cycles = 0;
    quiet = 0; in_gap = 0; out_hold = 0;
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed: reset registers, then caps opened up, then caps at zero with full gains
    add(65536, 0, 0, 0, 0, 16384, 0);            // disarmed, ignored
    add(100, -100, 0, 0, 0, 16384, 1);           // within reach radius
    add(0, 0, 0, 0, 0, 16384, 0);                // disarmed again
    drain();
    setup(0, 0, 256, 256, 262144, 65535, 6554);
    add(-67108864, -67108864, 0, 0, 0, 16384, 1);
    add(67108863, 67108863, 0, 0, 16384, 0, 0);
    add(67108863, -67108864, 16384, 0, 0, 0, 0);
    add(-67108864, 67108863, 0, 16384, 0, 0, 0);
    add(-65536, 0, 0, 0, 0, 0, 0);               // zero quaternion
    add(65536, 65536, 8192, 0, 8192, 0, 0);      // gimbal lock boundary
    add(0, 65536, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 0);
    add(-65536, -65536, 0, 0, 16'hc000, 16384, 0);
    add(65536, -65536, 0, 0, 11585, 11585, 0);
    add(0, -65536, 0, 0, 16'hd2bf, 11585, 0);
    add(0, 0, 0, 0, 0, 16384, 0);                // zero offset
    drain();
    setup(67108863, 67108864, 65535, 65535, 0, 0, 0);
    add(67108863, -67108864, 0, 0, 0, 16384, 1); // exact goal, radius zero
    add(67108862, -67108864, 0, 0, 0, 16384, 1);
    add(-67108864, 67108863, 0, 0, 0, 16384, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      quiet = (ph % 3 == 2);
      case (ph)
        0: setup(0, 0, 256, 256, 262144, 65535, 6554);
        1: setup($urandom(), $urandom(), $urandom(), $urandom(), $urandom_range(0, 262144),
                 $urandom(), $urandom_range(0, 262144));
        2: setup(67108863, 67108863, 0, 0, 524287, 0, 524287);
        3: setup(64'h4000000, 64'h4000000, 65535, 65535, 262144, 65535, 0);
        4: setup($urandom(), $urandom(), 256, 1024, 131072, 20000, 65536);
        5: setup(0, 0, 65535, 0, 0, 65535, 262144);
        6: setup($urandom(), $urandom(), 1, 65535, 262144, 12868, 1);
        default: setup($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom());
      endcase
      random_poses(205);
      drain();
    end

    repeat (300) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/gtg_pkg.sv
rtl/gtg_mul.sv
rtl/gtg_sqrt.sv
rtl/gtg_cordic.sv
rtl/go_to_goal_pose_controller.sv
tb/sv/testbench.sv
